/* sv/slpr_pkg.sv */
package slpr_pkg;

  // Coordinate and datapath widths
  localparam int CoordW    = 24;
  localparam int DiffW     = CoordW + 2;             // col + offset - centre
  localparam int MagW      = DiffW - 1;              // |d| < 2^25
  localparam int SqW       = 2 * MagW;               // d^2
  localparam int R2W       = SqW + 1;                // dx^2 + dy^2
  localparam int VShift    = 10;
  localparam int VW        = R2W + 1 + VShift;       // (f^2 + r^2) << 10
  localparam int RootW     = VW / 2;                 // Q5 root
  localparam int RemRootW  = RootW + 3;
  localparam int FqShift   = 5;
  localparam int FqW       = CoordW + FqShift;       // f in Q5
  localparam int NumW      = 2 * MagW;               // numerator, split in two halves
  localparam int DenW      = R2W;
  localparam int ProdW     = 2 * MagW;
  localparam int NW        = MagW + NumW;            // |d| * numerator
  localparam int QW        = 28;                     // quotient bits incl. one guard bit
  localparam int HiW       = NW - QW + 1;
  localparam int RemDivW   = DenW + 1;
  localparam int BaseW     = CoordW + 1;
  localparam int SumW      = QW + 2;
  localparam int AddrW     = 3;

  localparam logic [CoordW-1:0] FocalReset = CoordW'(256000);

  typedef enum logic [AddrW-1:0] {
    REG_CENTRE_X  = 3'd0,
    REG_CENTRE_Y  = 3'd1,
    REG_OFFSET_X  = 3'd2,
    REG_OFFSET_Y  = 3'd3,
    REG_FOCAL     = 3'd4,
    REG_DIRECTION = 3'd5
  } slpr_reg_e;

  // Values that ride along the root chain
  typedef struct packed {
    logic [MagW-1:0] mag_x;
    logic [MagW-1:0] mag_y;
    logic            neg_x;
    logic            neg_y;
    logic [R2W-1:0]  r2;
  } slpr_pass_t;

  typedef struct packed {
    logic [VW-1:0]       v;
    logic [RemRootW-1:0] rem;
    logic [RootW-1:0]    root;
    slpr_pass_t          pass;
  } slpr_root_t;

  // One component of the long division
  typedef struct packed {
    logic [RemDivW-1:0] rem;
    logic [QW-1:0]      q;
    logic [QW-1:0]      low;
    logic               ovf;
    logic               zero;
    logic               minus;
  } slpr_lane_t;

  typedef struct packed {
    logic [DenW-1:0] den;
    slpr_lane_t      x;
    slpr_lane_t      y;
  } slpr_div_t;

endpackage

/* sv/slpr_root_cell.sv */
module slpr_root_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                vld_i,
  input  slpr_pkg::slpr_root_t d_i,
  output logic                vld_o,
  output slpr_pkg::slpr_root_t d_o
);
  import slpr_pkg::*;

  logic [RemRootW-1:0] rem_s;
  logic [RemRootW-1:0] trial;
  slpr_root_t          d_nxt;

  // One root bit per cell: bring down two radicand bits, try 4r+1
  always_comb begin
    rem_s = {d_i.rem[RemRootW-3:0], d_i.v[VW-1 -: 2]};
    trial = {1'b0, d_i.root, 2'b01};
    d_nxt = d_i;
    d_nxt.v = {d_i.v[VW-3:0], 2'b00};
    if (rem_s >= trial) begin
      d_nxt.rem  = rem_s - trial;
      d_nxt.root = {d_i.root[RootW-2:0], 1'b1};
    end else begin
      d_nxt.rem  = rem_s;
      d_nxt.root = {d_i.root[RootW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_o <= 1'b0;
    end else if (en) begin
      vld_o <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_o <= d_nxt;
    end
  end

endmodule

/* sv/slpr_div_cell.sv */
module slpr_div_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               vld_i,
  input  slpr_pkg::slpr_div_t d_i,
  output logic               vld_o,
  output slpr_pkg::slpr_div_t d_o
);
  import slpr_pkg::*;

  slpr_div_t d_nxt;

  // Bring down one dividend bit, subtract the divisor if it fits
  function automatic slpr_lane_t lane_step(slpr_lane_t l, logic [DenW-1:0] den);
    logic [RemDivW-1:0] rem_s;
    logic               ge;
    slpr_lane_t         r;
    rem_s   = {l.rem[RemDivW-2:0], l.low[QW-1]};
    ge      = rem_s >= {1'b0, den};
    r       = l;
    r.low   = {l.low[QW-2:0], 1'b0};
    r.rem   = ge ? rem_s - {1'b0, den} : rem_s;
    r.q     = {l.q[QW-2:0], ge};
    return r;
  endfunction

  always_comb begin
    d_nxt     = d_i;
    d_nxt.x   = lane_step(d_i.x, d_i.den);
    d_nxt.y   = lane_step(d_i.y, d_i.den);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_o <= 1'b0;
    end else if (en) begin
      vld_o <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_o <= d_nxt;
    end
  end

endmodule

/* sv/stereographic_lens_point_remap.sv */
// Throughput: one item per cycle while in_tready is high; the 31-cell root chain and the
// 28-cell divider chain each advance one step per cycle, so an item enters every clock.
// Backpressure: an output register plus one skid entry; in_tready drops only while the
// skid entry holds an item. Reset (rst_n low, synchronous) clears all valid bits and
// loads the register defaults; payload registers are not reset.
module stereographic_lens_point_remap (
  input  logic                         clk,
  input  logic                         rst_n,
  // input items
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [2*slpr_pkg::CoordW-1:0] in_tdata,   // col [23:0], row [47:24]
  // result items
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [2*slpr_pkg::CoordW-1:0] out_tdata,  // out_col [23:0], out_row [47:24]
  output logic                         out_tuser,   // saturated
  // configuration writes
  input  logic                         cfg_we,
  input  logic [slpr_pkg::AddrW-1:0]   cfg_addr,
  input  logic [slpr_pkg::CoordW-1:0]  cfg_wdata
);
  import slpr_pkg::*;

  typedef struct packed {
    logic [CoordW-1:0] val;
    logic              sat;
  } slpr_res_t;

  localparam logic signed [SumW-1:0] OutMax = SumW'(2**(CoordW-1) - 1);
  localparam logic signed [SumW-1:0] OutMin = -SumW'(2**(CoordW-1));

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [CoordW-1:0] centre_x_r, centre_y_r, offset_x_r, offset_y_r, focal_r;
  logic              dir_r;
  logic [SqW-3:0]    f2_r;  // f^2, registered from focal_r

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      centre_x_r <= '0;
      centre_y_r <= '0;
      offset_x_r <= '0;
      offset_y_r <= '0;
      focal_r    <= FocalReset;
      dir_r      <= 1'b0;
    end else if (cfg_we) begin
      unique case (slpr_reg_e'(cfg_addr))
        REG_CENTRE_X:  centre_x_r <= cfg_wdata;
        REG_CENTRE_Y:  centre_y_r <= cfg_wdata;
        REG_OFFSET_X:  offset_x_r <= cfg_wdata;
        REG_OFFSET_Y:  offset_y_r <= cfg_wdata;
        REG_FOCAL:     focal_r    <= cfg_wdata;
        REG_DIRECTION: dir_r      <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    f2_r <= focal_r * focal_r;
  end

  // The whole pipeline moves together; it freezes only while the skid entry is full
  logic en;
  logic skid_vld_r;
  assign en        = !skid_vld_r;
  assign in_tready = en;

  // ---------------------------------------------------------------------------
  // Front: offset from the centre, magnitudes, squares, radius squared
  // ---------------------------------------------------------------------------
  logic signed [DiffW-1:0] dx_nxt, dy_nxt, dx_r, dy_r;
  logic                    v0_r, v1_r, v2_r;
  logic [MagW-1:0]         mag_x1_r, mag_y1_r;
  logic                    neg_x1_r, neg_y1_r;
  logic [SqW-1:0]          sq_x_r, sq_y_r;
  logic [DiffW-1:0]        abs_x, abs_y;
  slpr_pass_t              pass2_r;

  always_comb begin
    dx_nxt = {{2{in_tdata[CoordW-1]}}, in_tdata[CoordW-1:0]}
           + {{2{offset_x_r[CoordW-1]}}, offset_x_r}
           - {{2{centre_x_r[CoordW-1]}}, centre_x_r};
    dy_nxt = {{2{in_tdata[2*CoordW-1]}}, in_tdata[2*CoordW-1:CoordW]}
           + {{2{offset_y_r[CoordW-1]}}, offset_y_r}
           - {{2{centre_y_r[CoordW-1]}}, centre_y_r};
    abs_x  = dx_r[DiffW-1] ? -dx_r : dx_r;
    abs_y  = dy_r[DiffW-1] ? -dy_r : dy_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_tvalid;
      v1_r <= v0_r;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx_r          <= dx_nxt;
      dy_r          <= dy_nxt;
      mag_x1_r      <= abs_x[MagW-1:0];
      mag_y1_r      <= abs_y[MagW-1:0];
      neg_x1_r      <= dx_r[DiffW-1];
      neg_y1_r      <= dy_r[DiffW-1];
      sq_x_r        <= abs_x[MagW-1:0] * abs_x[MagW-1:0];
      sq_y_r        <= abs_y[MagW-1:0] * abs_y[MagW-1:0];
      pass2_r.mag_x <= mag_x1_r;
      pass2_r.mag_y <= mag_y1_r;
      pass2_r.neg_x <= neg_x1_r;
      pass2_r.neg_y <= neg_y1_r;
      pass2_r.r2    <= {1'b0, sq_x_r} + {1'b0, sq_y_r};
    end
  end

  // ---------------------------------------------------------------------------
  // Root chain: floor(sqrt((f^2 + r^2) << 10)), one result bit per cell
  // ---------------------------------------------------------------------------
  logic       root_vld [0:RootW];
  slpr_root_t root_d   [0:RootW];

  always_comb begin
    root_vld[0]     = v2_r;
    root_d[0].v     = {({2'b00, f2_r} + {1'b0, pass2_r.r2}), {VShift{1'b0}}};
    root_d[0].rem   = '0;
    root_d[0].root  = '0;
    root_d[0].pass  = pass2_r;
  end

  for (genvar k = 0; k < RootW; k++) begin : g_root
    slpr_root_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .vld_i (root_vld[k]),
      .d_i   (root_d[k]),
      .vld_o (root_vld[k+1]),
      .d_o   (root_d[k+1])
    );
  end

  // ---------------------------------------------------------------------------
  // Scale terms: forward num 2F, den F+S; inverse num 4f^2, den |4f^2 - r^2|
  // ---------------------------------------------------------------------------
  slpr_pass_t             pass_end;
  logic [FqW-1:0]         fq;
  logic signed [DenW:0]   dd;
  logic [DenW-1:0]        den_nxt;
  logic [NumW-1:0]        num_nxt;
  logic                   dneg_nxt;

  logic                   vd_r;
  logic [DenW-1:0]        den_r;
  logic [NumW-1:0]        num_r;
  logic                   dneg_r;
  logic [MagW-1:0]        mag_xd_r, mag_yd_r;
  logic                   neg_xd_r, neg_yd_r;

  always_comb begin
    pass_end = root_d[RootW].pass;
    fq       = {focal_r, {FqShift{1'b0}}};
    dd       = $signed({2'b00, f2_r, 2'b00}) - $signed({1'b0, pass_end.r2});
    if (dir_r) begin
      num_nxt  = {f2_r, 2'b00};
      dneg_nxt = dd[DenW];
      den_nxt  = dd[DenW] ? DenW'(-dd) : DenW'(dd);
    end else begin
      num_nxt  = NumW'({fq, 1'b0});
      dneg_nxt = 1'b0;
      den_nxt  = DenW'(fq) + DenW'(root_d[RootW].root);
    end
  end

  // Multiply |d| by the numerator in two halves, then join and set up the division
  logic                vm_r;
  logic [ProdW-1:0]    px_lo_r, px_hi_r, py_lo_r, py_hi_r;
  logic [DenW-1:0]     den_m_r;
  logic                minus_x_r, minus_y_r, zero_x_r, zero_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vd_r <= 1'b0;
      vm_r <= 1'b0;
    end else if (en) begin
      vd_r <= root_vld[RootW];
      vm_r <= vd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den_r     <= den_nxt;
      num_r     <= num_nxt;
      dneg_r    <= dneg_nxt;
      mag_xd_r  <= pass_end.mag_x;
      mag_yd_r  <= pass_end.mag_y;
      neg_xd_r  <= pass_end.neg_x;
      neg_yd_r  <= pass_end.neg_y;
      px_lo_r   <= mag_xd_r * num_r[MagW-1:0];
      px_hi_r   <= mag_xd_r * num_r[NumW-1:MagW];
      py_lo_r   <= mag_yd_r * num_r[MagW-1:0];
      py_hi_r   <= mag_yd_r * num_r[NumW-1:MagW];
      den_m_r   <= den_r;
      minus_x_r <= neg_xd_r ^ dneg_r;
      minus_y_r <= neg_yd_r ^ dneg_r;
      zero_x_r  <= (mag_xd_r == '0);
      zero_y_r  <= (mag_yd_r == '0);
    end
  end

  // Division of 2N by den: high part seeds the remainder; if it already reaches
  // den the quotient is beyond any representable result
  function automatic slpr_lane_t lane_init(logic [ProdW-1:0] hi_p, logic [ProdW-1:0] lo_p,
                                           logic [DenW-1:0] den, logic zero, logic minus);
    logic [NW-1:0] n;
    logic [HiW-1:0] hi;
    slpr_lane_t     l;
    n       = {hi_p, {MagW{1'b0}}} + NW'(lo_p);
    hi      = n[NW-1:QW-1];
    l.rem   = RemDivW'(hi);
    l.q     = '0;
    l.low   = {n[QW-2:0], 1'b0};
    l.ovf   = !zero && (DenW'(hi) >= den);
    l.zero  = zero;
    l.minus = minus;
    return l;
  endfunction

  logic      div_vld [0:QW];
  slpr_div_t div_d   [0:QW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_vld[0] <= 1'b0;
    end else if (en) begin
      div_vld[0] <= vm_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      div_d[0].den <= den_m_r;
      div_d[0].x   <= lane_init(px_hi_r, px_lo_r, den_m_r, zero_x_r, minus_x_r);
      div_d[0].y   <= lane_init(py_hi_r, py_lo_r, den_m_r, zero_y_r, minus_y_r);
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_div
    slpr_div_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .vld_i (div_vld[k]),
      .d_i   (div_d[k]),
      .vld_o (div_vld[k+1]),
      .d_o   (div_d[k+1])
    );
  end

  // ---------------------------------------------------------------------------
  // Round half away from zero, add to centre - offset, saturate
  // ---------------------------------------------------------------------------
  function automatic slpr_res_t lane_out(slpr_lane_t l, logic signed [BaseW-1:0] base);
    logic [QW:0]             qi;
    logic signed [SumW-1:0]  q_ext;
    logic signed [SumW-1:0]  b_ext;
    logic signed [SumW-1:0]  s;
    slpr_res_t               r;
    qi    = {1'b0, l.q} + (QW+1)'(1);
    q_ext = {{(SumW-QW){1'b0}}, qi[QW:1]};
    b_ext = {{(SumW-BaseW){base[BaseW-1]}}, base};
    if (l.zero) begin
      s = b_ext;
    end else if (l.minus) begin
      s = b_ext - q_ext;
    end else begin
      s = b_ext + q_ext;
    end
    r.sat = 1'b0;
    priority if (l.ovf) begin
      r.sat = 1'b1;
      r.val = l.minus ? OutMin[CoordW-1:0] : OutMax[CoordW-1:0];
    end else if (s > OutMax) begin
      r.sat = 1'b1;
      r.val = OutMax[CoordW-1:0];
    end else if (s < OutMin) begin
      r.sat = 1'b1;
      r.val = OutMin[CoordW-1:0];
    end else begin
      r.val = s[CoordW-1:0];
    end
    return r;
  endfunction

  logic signed [BaseW-1:0] base_x, base_y;
  slpr_res_t               res_x, res_y;
  logic [2*CoordW-1:0]     res_data;
  logic                    res_sat;

  always_comb begin
    base_x   = $signed({centre_x_r[CoordW-1], centre_x_r})
             - $signed({offset_x_r[CoordW-1], offset_x_r});
    base_y   = $signed({centre_y_r[CoordW-1], centre_y_r})
             - $signed({offset_y_r[CoordW-1], offset_y_r});
    res_x    = lane_out(div_d[QW].x, base_x);
    res_y    = lane_out(div_d[QW].y, base_y);
    res_data = {res_y.val, res_x.val};
    res_sat  = res_x.sat | res_y.sat;
  end

  // ---------------------------------------------------------------------------
  // Output register and skid entry
  // ---------------------------------------------------------------------------
  logic                out_vld_r;
  logic [2*CoordW-1:0] out_data_r, skid_data_r;
  logic                out_sat_r, skid_sat_r;
  logic                take, push, to_skid;

  assign take    = out_vld_r && out_tready;
  assign push    = en && div_vld[QW];
  // a fresh result parks in the skid entry only if the output register stays full
  assign to_skid = push && out_vld_r && !out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      if (to_skid) begin
        skid_vld_r <= 1'b1;
      end else if (take) begin
        skid_vld_r <= 1'b0;
      end
      if (push || (take && skid_vld_r)) begin
        out_vld_r <= 1'b1;
      end else if (take) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (to_skid) begin
      skid_data_r <= res_data;
      skid_sat_r  <= res_sat;
    end
    if (take && skid_vld_r) begin
      out_data_r <= skid_data_r;
      out_sat_r  <= skid_sat_r;
    end else if (push && !to_skid) begin
      out_data_r <= res_data;
      out_sat_r  <= res_sat;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_sat_r;

endmodule

/* sv/slpr_checker.sv */
module slpr_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_tready,
  input logic                          out_tvalid,
  input logic                          out_tready,
  input logic [2*slpr_pkg::CoordW-1:0] out_tdata,
  input logic                          out_tuser
);
  import slpr_pkg::*;

  // A stalled result item holds its payload
  a_hold_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("result payload changed while stalled");

  // Reset leaves no result pending
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // Input backpressure only follows a stalled output
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> $past(out_tvalid && !out_tready))
    else $error("input stalled without output backpressure");

  // Taking a result always frees the skid entry
  a_take_frees: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready |=> in_tready)
    else $error("input still stalled after a result was taken");

endmodule

bind stereographic_lens_point_remap slpr_checker u_slpr_checker (.*);
